/* rtl/bpe_pkg.sv */
// Shared types and constants of the byte pair expander.
`default_nettype none
package bpe_pkg;

    localparam int STACK_DEPTH_DEF   = 256;
    localparam int MAX_EXPANSION_DEF = 64;

    localparam logic [7:0] SKIP_BIAS = 8'd127;
    localparam int         CODES     = 256;

    typedef enum logic [2:0] {
        PH_BLOCK = 3'd0,
        PH_COUNT = 3'd1,
        PH_PAIR  = 3'd2,
        PH_SIZE  = 3'd3,
        PH_DATA  = 3'd4
    } t_phase;

    typedef enum logic [1:0] {
        S_IDLE = 2'd0,
        S_EVAL = 2'd1,
        S_POP  = 2'd2
    } t_state;

endpackage
`default_nettype wire

/* rtl/byte_pair_expander.sv */
// Byte pair decompressor: stream parser, pair memory and expansion stack.
`default_nettype none
// Table, count and size bytes are taken one per cycle. A data byte stalls the
// input while it is expanded through the pair memory and the stack memory:
// a first pass finds the result count and whether the expansion is cut, and
// a second pass, run only when that count is not zero, sends the literals.
// Each pass handles a pair by pushing its right code on the stack and reading
// its left code from the pair memory, and a literal by a stack pop and then a
// pair memory read, both skipped for the last literal; the second pass also
// waits while the output is stalled. The left table reverts to identity at
// every block start through per-entry valid bits, so no clearing pass is
// needed.
module byte_pair_expander
    import bpe_pkg::*;
#(
    parameter int STACK_DEPTH   = STACK_DEPTH_DEF,
    parameter int MAX_EXPANSION = MAX_EXPANSION_DEF
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_stall,
    input  wire logic [7:0] i_in_byte,
    output logic            o_valid,
    input  wire logic       i_stall,
    output logic [7:0]      o_out_byte,
    output logic            o_last_of_run,
    output logic            o_expansion_overflow
);

    localparam int SP_W  = $clog2(STACK_DEPTH + 1);
    localparam int IDX_W = $clog2(STACK_DEPTH);
    localparam int N_W   = $clog2(MAX_EXPANSION + 1);
    localparam logic [SP_W-1:0] SP_LIMIT = SP_W'(STACK_DEPTH - 1);
    localparam logic [N_W-1:0]  N_MAX    = N_W'(MAX_EXPANSION);

    t_state r_state, n_state;
    t_phase r_phase, n_phase;
    logic [8:0]      r_tc, n_tc;
    logic [7:0]      r_run, n_run;
    logic            r_await, n_await;
    logic [31:0]     r_size, n_size;
    logic [1:0]      r_sidx, n_sidx;
    logic [7:0]      r_start, n_start;
    logic [SP_W-1:0] r_sp, n_sp;
    logic [N_W-1:0]  r_n, n_n;
    logic [N_W-1:0]  r_total, n_total;
    logic            r_pass, n_pass;
    logic            r_cut, n_cut;
    logic            r_out_valid, n_out_valid;
    logic [7:0]      r_out_byte, n_out_byte;
    logic            r_out_last, n_out_last;
    logic            r_out_ovf, n_out_ovf;

    logic [15:0] r_pair_mem [CODES];
    logic [255:0] r_lvalid;
    logic [15:0] r_pm_q;
    logic        r_lv;
    logic [7:0]  r_c;
    logic        pm_re, pm_we_l, pm_we_r, lv_clr;
    logic [7:0]  pm_raddr, pm_waddr, pm_wdata;

    logic [7:0]       r_stack [STACK_DEPTH];
    logic [7:0]       r_st_q;
    logic             st_re, st_we;
    logic [IDX_W-1:0] st_raddr;

    logic            acc, out_free, lit, full, n_at_max, sp_zero, last1;
    logic [7:0]      ev_left, ev_right;
    logic [SP_W-1:0] sp_dec;
    logic [N_W-1:0]  n_inc, n_final0;
    logic [9:0]      skip_code;
    logic [8:0]      tc_base, tc_inc;
    logic [31:0]     size_or;
    logic [7:0]      code8;

    assign acc      = i_valid && !o_stall;
    assign out_free = !r_out_valid || !i_stall;
    assign ev_left  = r_lv ? r_pm_q[15:8] : r_c;
    assign ev_right = r_pm_q[7:0];
    assign lit      = (ev_left == r_c);
    assign full     = (r_sp >= SP_LIMIT);
    assign n_at_max = (r_n >= N_MAX);
    assign sp_zero  = (r_sp == '0);
    assign sp_dec   = r_sp - SP_W'(1);
    assign st_raddr = sp_dec[IDX_W-1:0];
    assign n_inc    = r_n + N_W'(1);
    assign n_final0 = (lit && !n_at_max) ? n_inc : r_n;
    assign last1    = (n_inc == r_total);
    assign tc_base  = (r_phase == PH_BLOCK) ? 9'd0 : r_tc;
    assign skip_code = {1'b0, tc_base} + {2'b00, i_in_byte - SKIP_BIAS};
    assign tc_inc   = r_tc + 9'd1;
    assign code8    = r_tc[7:0];
    assign size_or  = r_size | ({24'd0, i_in_byte} << {r_sidx, 3'b000});

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (acc && r_phase == PH_DATA) n_state = S_EVAL;
            end
            S_EVAL: begin
                if (!r_pass) begin
                    if ((lit && (n_at_max || sp_zero)) || (!lit && full)) begin
                        n_state = (n_final0 == '0) ? S_IDLE : S_EVAL;
                    end else if (lit) begin
                        n_state = S_POP;
                    end
                end else if (lit) begin
                    if (out_free) n_state = last1 ? S_IDLE : S_POP;
                end
            end
            S_POP: n_state = S_EVAL;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_phase = r_phase;
        n_tc = r_tc;
        n_run = r_run;
        n_await = r_await;
        n_size = r_size;
        n_sidx = r_sidx;
        n_start = r_start;
        n_sp = r_sp;
        n_n = r_n;
        n_total = r_total;
        n_pass = r_pass;
        n_cut = r_cut;
        n_out_valid = r_out_valid && i_stall;
        n_out_byte = r_out_byte;
        n_out_last = r_out_last;
        n_out_ovf = r_out_ovf;
        pm_re = 1'b0;
        pm_raddr = r_c;
        pm_we_l = 1'b0;
        pm_we_r = 1'b0;
        pm_waddr = code8;
        pm_wdata = i_in_byte;
        lv_clr = 1'b0;
        st_re = 1'b0;
        st_we = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (acc) begin
                    unique case (r_phase)
                        PH_PAIR: begin
                            if (!r_await) begin
                                pm_we_l = 1'b1;
                                n_await = (i_in_byte != code8);
                            end else begin
                                pm_we_r = 1'b1;
                                n_await = 1'b0;
                            end
                            if (r_await || i_in_byte == code8) begin
                                n_tc = tc_inc;
                                if (tc_inc[8]) begin
                                    n_phase = PH_SIZE;
                                    n_size = '0;
                                    n_sidx = '0;
                                end else if (r_run == '0) begin
                                    n_phase = PH_COUNT;
                                end else begin
                                    n_run = r_run - 8'd1;
                                end
                            end
                        end
                        PH_SIZE: begin
                            n_size = size_or;
                            n_sidx = r_sidx + 2'd1;
                            if (r_sidx == 2'd3) begin
                                n_phase = (size_or == '0) ? PH_BLOCK : PH_DATA;
                            end
                        end
                        PH_DATA: begin
                            n_size = r_size - 32'd1;
                            if (r_size == 32'd1) n_phase = PH_BLOCK;
                            n_start = i_in_byte;
                            n_sp = '0;
                            n_n = '0;
                            n_pass = 1'b0;
                            n_cut = 1'b0;
                            pm_re = 1'b1;
                            pm_raddr = i_in_byte;
                        end
                        default: begin
                            lv_clr = (r_phase != PH_COUNT);
                            n_await = 1'b0;
                            if (i_in_byte[7]) begin
                                if (skip_code[9:8] != 2'b00) begin
                                    n_tc = 9'(CODES);
                                    n_phase = PH_SIZE;
                                    n_size = '0;
                                    n_sidx = '0;
                                end else begin
                                    n_tc = skip_code[8:0];
                                    n_run = '0;
                                    n_phase = PH_PAIR;
                                end
                            end else begin
                                n_tc = tc_base;
                                n_run = i_in_byte;
                                n_phase = PH_PAIR;
                            end
                        end
                    endcase
                end
            end
            S_EVAL: begin
                if (!r_pass) begin
                    if ((lit && (n_at_max || sp_zero)) || (!lit && full)) begin
                        n_total = n_final0;
                        n_cut = lit ? n_at_max : 1'b1;
                        n_pass = 1'b1;
                        n_n = '0;
                        n_sp = '0;
                        pm_re = (n_final0 != '0);
                        pm_raddr = r_start;
                    end else if (lit) begin
                        n_n = n_inc;
                        st_re = 1'b1;
                        n_sp = sp_dec;
                    end else begin
                        st_we = 1'b1;
                        n_sp = r_sp + SP_W'(1);
                        pm_re = 1'b1;
                        pm_raddr = ev_left;
                    end
                end else if (lit) begin
                    if (out_free) begin
                        n_out_valid = 1'b1;
                        n_out_byte = r_c;
                        n_out_last = last1;
                        n_out_ovf = r_cut;
                        n_n = n_inc;
                        if (!last1) begin
                            st_re = 1'b1;
                            n_sp = sp_dec;
                        end
                    end
                end else begin
                    st_we = 1'b1;
                    n_sp = r_sp + SP_W'(1);
                    pm_re = 1'b1;
                    pm_raddr = ev_left;
                end
            end
            S_POP: begin
                pm_re = 1'b1;
                pm_raddr = r_st_q;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_phase <= PH_BLOCK;
            r_tc <= '0;
            r_run <= '0;
            r_await <= 1'b0;
            r_size <= '0;
            r_sidx <= '0;
            r_sp <= '0;
            r_n <= '0;
            r_total <= '0;
            r_pass <= 1'b0;
            r_cut <= 1'b0;
            r_out_valid <= 1'b0;
            r_lvalid <= '0;
        end else begin
            r_state <= n_state;
            r_phase <= n_phase;
            r_tc <= n_tc;
            r_run <= n_run;
            r_await <= n_await;
            r_size <= n_size;
            r_sidx <= n_sidx;
            r_sp <= n_sp;
            r_n <= n_n;
            r_total <= n_total;
            r_pass <= n_pass;
            r_cut <= n_cut;
            r_out_valid <= n_out_valid;
            if (lv_clr) begin
                r_lvalid <= '0;
            end else if (pm_we_l) begin
                r_lvalid[pm_waddr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_start <= n_start;
        r_out_byte <= n_out_byte;
        r_out_last <= n_out_last;
        r_out_ovf <= n_out_ovf;
    end

    always_ff @(posedge i_clk) begin
        if (pm_we_l) r_pair_mem[pm_waddr][15:8] <= pm_wdata;
        if (pm_we_r) r_pair_mem[pm_waddr][7:0] <= pm_wdata;
        if (pm_re) begin
            r_pm_q <= r_pair_mem[pm_raddr];
            r_lv <= r_lvalid[pm_raddr];
            r_c <= pm_raddr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (st_we) r_stack[r_sp[IDX_W-1:0]] <= ev_right;
        if (st_re) r_st_q <= r_stack[st_raddr];
    end

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = r_out_valid;
    assign o_out_byte = r_out_byte;
    assign o_last_of_run = r_out_last;
    assign o_expansion_overflow = r_out_ovf;

endmodule
`default_nettype wire

/* rtl/bpe_checker.sv */
// Port-level assertions for the byte pair expander, bound into every byte_pair_expander instance.
`default_nettype none
module bpe_checker
    import bpe_pkg::*;
#(
    parameter int MAX_EXPANSION = MAX_EXPANSION_DEF
) (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       o_valid,
    input wire logic       i_stall,
    input wire logic [7:0] o_out_byte,
    input wire logic       o_last_of_run,
    input wire logic       o_expansion_overflow
);

    localparam int N_W = $clog2(MAX_EXPANSION + 1);

    logic           r_in_run;
    logic           r_run_ovf;
    logic [N_W-1:0] r_cnt;
    logic           out_acc;

    assign out_acc = o_valid && !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_run <= 1'b0;
            r_run_ovf <= 1'b0;
            r_cnt <= '0;
        end else if (out_acc) begin
            if (o_last_of_run) begin
                r_in_run <= 1'b0;
                r_cnt <= '0;
            end else begin
                r_in_run <= 1'b1;
                r_cnt <= r_cnt + N_W'(1);
                r_run_ovf <= o_expansion_overflow;
            end
        end
    end

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_out_byte) && $stable(o_last_of_run))
        else $error("stalled item changed");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("item shown right after reset");

    a_ovf_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && r_in_run |-> o_expansion_overflow == r_run_ovf)
        else $error("overflow flag changed inside a run");

    a_run_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> r_cnt < N_W'(MAX_EXPANSION))
        else $error("run longer than the expansion limit");

endmodule

bind byte_pair_expander bpe_checker #(.MAX_EXPANSION(MAX_EXPANSION)) u_bpe_checker (.*);
`default_nettype wire

/* dv/tb_byte_pair_expander.sv */
// Testbench for the byte pair expander: directed and random streams checked by a predictor.
`timescale 1ns / 1ps
module tb_byte_pair_expander
    import bpe_pkg::*;
();

    localparam int unsigned CYCLE_LIMIT  = 1_000_000;
    localparam int unsigned DRAIN_CYCLES = 2000;
    localparam int unsigned HOLD_CYCLES  = 400;
    localparam int unsigned RANDOM_ITEMS = 160;
    localparam int unsigned PRINT_CAP    = 100;

    typedef enum logic [1:0] {
        ROW_NONE,
        ROW_ONE,
        ROW_PRED
    } t_row_kind;

    typedef struct packed {
        t_row_kind  kind;
        logic [7:0] in_byte;
        logic [7:0] lit;
    } t_row;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       ovf;
    } t_lit_rec;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_valid;
    logic       o_stall;
    logic [7:0] i_in_byte;
    logic       o_valid;
    logic       i_stall;
    logic [7:0] o_out_byte;
    logic       o_last_of_run;
    logic       o_expansion_overflow;

    t_row        dir_rows[$];
    logic [7:0]  stream_q[$];
    t_lit_rec    lit_q[$];
    t_lit_rec    pending_out_q[$];
    t_lit_rec    head_rec;
    int unsigned snd_idle_pct = 36;
    int unsigned rcv_idle_pct = 75;
    int unsigned err_cnt      = 0;
    int unsigned cycle_cnt    = 0;
    bit          hold_req     = 1'b0;

    logic [7:0]  left_code[CODES];
    logic [7:0]  right_code[CODES];
    logic [7:0]  walk_stack[STACK_DEPTH_DEF];
    t_phase      parse_ph;
    logic [8:0]  tab_code;
    logic [7:0]  run_left;
    logic        want_right;
    logic [31:0] size_left;
    logic [1:0]  size_idx;

    byte_pair_expander i_dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_valid             (i_valid),
        .o_stall             (o_stall),
        .i_in_byte           (i_in_byte),
        .o_valid             (o_valid),
        .i_stall             (i_stall),
        .o_out_byte          (o_out_byte),
        .o_last_of_run       (o_last_of_run),
        .o_expansion_overflow(o_expansion_overflow)
    );

    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    task automatic report_mismatch(input string msg);
        if (err_cnt < PRINT_CAP) begin
            $display("mismatch at cycle %0d: %s", cycle_cnt, msg);
        end
        err_cnt++;
    endtask

    function automatic void start_size();
        parse_ph  = PH_SIZE;
        size_left = '0;
        size_idx  = '0;
    endfunction

    function automatic void decode_byte(input logic [7:0] b);
        int          i;
        int          nxt;
        logic [7:0]  c8;
        logic [7:0]  lits[MAX_EXPANSION_DEF];
        int unsigned sp;
        int unsigned n;
        bit          cut;
        bit          done;
        t_lit_rec    rec;
        lit_q.delete();
        case (parse_ph) inside
            PH_BLOCK, PH_COUNT: begin
                if (parse_ph == PH_BLOCK) begin
                    for (i = 0; i < CODES; i++) begin
                        left_code[i] = 8'(i);
                    end
                    tab_code = '0;
                end
                want_right = 1'b0;
                if (b > SKIP_BIAS) begin
                    nxt = int'(tab_code) + int'(b) - int'(SKIP_BIAS);
                    if (nxt >= CODES) begin
                        tab_code = 9'd256;
                        start_size();
                        return;
                    end
                    tab_code = 9'(nxt);
                    run_left = '0;
                end else begin
                    run_left = b;
                end
                parse_ph = PH_PAIR;
            end
            PH_PAIR: begin
                c8 = tab_code[7:0];
                if (!want_right) begin
                    left_code[c8] = b;
                    if (b != c8) begin
                        want_right = 1'b1;
                        return;
                    end
                end else begin
                    right_code[c8] = b;
                    want_right     = 1'b0;
                end
                tab_code = tab_code + 9'd1;
                if (tab_code >= CODES) begin
                    start_size();
                end else if (run_left == 0) begin
                    parse_ph = PH_COUNT;
                end else begin
                    run_left = run_left - 8'd1;
                end
            end
            PH_SIZE: begin
                size_left = size_left | (32'(b) << (8 * size_idx));
                size_idx  = size_idx + 2'd1;
                if (size_idx == 0) begin
                    parse_ph = (size_left == 0) ? PH_BLOCK : PH_DATA;
                end
            end
            default: begin
                size_left = size_left - 32'd1;
                c8   = b;
                sp   = 0;
                n    = 0;
                cut  = 1'b0;
                done = 1'b0;
                while (!done) begin
                    if (left_code[c8] == c8) begin
                        if (n >= MAX_EXPANSION_DEF) begin
                            cut  = 1'b1;
                            done = 1'b1;
                        end else begin
                            lits[n] = c8;
                            n++;
                        end
                    end else if (sp + 2 > STACK_DEPTH_DEF) begin
                        cut  = 1'b1;
                        done = 1'b1;
                    end else begin
                        walk_stack[sp]     = right_code[c8];
                        walk_stack[sp + 1] = left_code[c8];
                        sp += 2;
                    end
                    if (!done) begin
                        if (sp == 0) begin
                            done = 1'b1;
                        end else begin
                            sp--;
                            c8 = walk_stack[sp];
                        end
                    end
                end
                for (i = 0; i < int'(n); i++) begin
                    rec.data = lits[i];
                    rec.last = (i + 1 == int'(n));
                    rec.ovf  = cut;
                    lit_q.push_back(rec);
                end
                if (size_left == 0) begin
                    parse_ph = PH_BLOCK;
                end
            end
        endcase
    endfunction

    function automatic void add_row(input t_row_kind kind, input logic [7:0] b,
                                    input logic [7:0] lit);
        t_row r;
        r.kind    = kind;
        r.in_byte = b;
        r.lit     = lit;
        dir_rows.push_back(r);
    endfunction

    function automatic void gen_block(input bit wild);
        int         code;
        int         n;
        int         k;
        int         len;
        logic [7:0] lft;
        logic [7:0] pair_codes[$];
        code = 0;
        while (code < CODES) begin
            if ($urandom_range(2) == 0) begin
                n = (code >= 250 && $urandom_range(1) == 1) ? 127 : $urandom_range(3);
                stream_q.push_back(8'(n));
            end else begin
                k = $urandom_range(1, 128);
                stream_q.push_back(8'(k + 127));
                code += k;
                n = 0;
            end
            for (k = 0; k <= n && code < CODES; k++) begin
                if ($urandom_range(3) == 0 || (!wild && code == 0)) begin
                    stream_q.push_back(8'(code));
                end else begin
                    lft = wild ? 8'($urandom_range(255)) : 8'($urandom_range(code - 1));
                    stream_q.push_back(lft);
                    if (lft != 8'(code)) begin
                        stream_q.push_back(wild ? 8'($urandom_range(255))
                                                : 8'($urandom_range(code - 1)));
                        pair_codes.push_back(8'(code));
                    end
                end
                code++;
            end
        end
        len = ($urandom_range(5) == 0) ? 0 : $urandom_range(1, 12);
        stream_q.push_back(8'(len));
        stream_q.push_back(8'd0);
        stream_q.push_back(8'd0);
        stream_q.push_back(8'd0);
        for (k = 0; k < len; k++) begin
            if (pair_codes.size() != 0 && $urandom_range(1) == 1) begin
                stream_q.push_back(pair_codes[$urandom_range(pair_codes.size() - 1)]);
            end else begin
                stream_q.push_back(8'($urandom_range(255)));
            end
        end
    endfunction

    task automatic send_item(input logic [7:0] b, input t_row_kind kind,
                             input logic [7:0] lit);
        t_lit_rec rec;
        while ($urandom_range(99) < snd_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_in_byte <= b;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        decode_byte(b);
        if (kind == ROW_PRED) begin
            foreach (lit_q[j]) pending_out_q.push_back(lit_q[j]);
        end else if (kind == ROW_ONE) begin
            rec.data = lit;
            rec.last = 1'b1;
            rec.ovf  = 1'b0;
            pending_out_q.push_back(rec);
        end
    endtask

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && o_valid === 1'b1 && i_stall === 1'b0) begin
            if (pending_out_q.size() == 0) begin
                report_mismatch($sformatf("unexpected byte %0d", o_out_byte));
            end else begin
                head_rec = pending_out_q.pop_front();
                if (o_out_byte !== head_rec.data) begin
                    report_mismatch($sformatf("out_byte %0d, want %0d",
                                              o_out_byte, head_rec.data));
                end
                if (o_last_of_run !== head_rec.last) begin
                    report_mismatch($sformatf("last_of_run %b, want %b",
                                              o_last_of_run, head_rec.last));
                end
                if (o_expansion_overflow !== head_rec.ovf) begin
                    report_mismatch($sformatf("expansion_overflow %b, want %b",
                                              o_expansion_overflow, head_rec.ovf));
                end
            end
        end
    end

    initial begin : receiver
        int unsigned n;
        i_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                i_stall <= 1'b1;
                for (n = 0; n < HOLD_CYCLES; n++) @(posedge i_clk);
                hold_req = 1'b0;
            end
            i_stall <= ($urandom_range(99) < rcv_idle_pct);
        end
    end

    initial begin : stimulus
        int unsigned k;
        int unsigned total;
        i_rst_n   <= 1'b0;
        i_valid   <= 1'b0;
        i_in_byte <= '0;
        for (k = 0; k < CODES; k++) begin
            left_code[k]  = 8'(k);
            right_code[k] = '0;
        end
        parse_ph   = PH_BLOCK;
        tab_code   = '0;
        run_left   = '0;
        want_right = 1'b0;
        size_left  = '0;
        size_idx   = '0;

        // empty block: skip, literal entry, skip past the table end, zero size
        add_row(ROW_NONE, 8'd255, 8'd0);
        add_row(ROW_NONE, 8'd128, 8'd0);
        add_row(ROW_NONE, 8'd255, 8'd0);
        add_row(ROW_NONE, 8'd0, 8'd0);
        add_row(ROW_NONE, 8'd0, 8'd0);
        add_row(ROW_NONE, 8'd0, 8'd0);
        add_row(ROW_NONE, 8'd0, 8'd0);
        // code 0 literal, 129 repeats itself, 254 and 255 form a loop, run past the end
        add_row(ROW_NONE, 8'd0, 8'd0);
        add_row(ROW_NONE, 8'd0, 8'd0);
        add_row(ROW_NONE, 8'd255, 8'd0);
        add_row(ROW_NONE, 8'd65, 8'd0);
        add_row(ROW_NONE, 8'd129, 8'd0);
        add_row(ROW_NONE, 8'd251, 8'd0);
        add_row(ROW_NONE, 8'd255, 8'd0);
        add_row(ROW_NONE, 8'd66, 8'd0);
        add_row(ROW_NONE, 8'd127, 8'd0);
        add_row(ROW_NONE, 8'd254, 8'd0);
        add_row(ROW_NONE, 8'd67, 8'd0);
        add_row(ROW_NONE, 8'd5, 8'd0);
        add_row(ROW_NONE, 8'd0, 8'd0);
        add_row(ROW_NONE, 8'd0, 8'd0);
        add_row(ROW_NONE, 8'd0, 8'd0);
        add_row(ROW_ONE, 8'd65, 8'd65);
        add_row(ROW_NONE, 8'd255, 8'd0);
        add_row(ROW_PRED, 8'd129, 8'd0);
        add_row(ROW_NONE, 8'd254, 8'd0);
        add_row(ROW_ONE, 8'd0, 8'd0);

        while (stream_q.size() < RANDOM_ITEMS) begin
            gen_block($urandom_range(4) == 0);
        end
        for (k = 0; k < 12; k++) begin
            stream_q.push_back(8'($urandom_range(255)));
        end

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (k = 0; k < dir_rows.size(); k++) begin
            send_item(dir_rows[k].in_byte, dir_rows[k].kind, dir_rows[k].lit);
        end

        total = stream_q.size();
        for (k = 0; k < total; k++) begin
            if (k == total / 3) begin
                snd_idle_pct = 75;
                rcv_idle_pct = 36;
            end
            if (k == 2 * total / 3) begin
                snd_idle_pct = 0;
                rcv_idle_pct = 0;
                hold_req     = 1'b1;
            end
            send_item(stream_q[k], ROW_PRED, 8'd0);
        end
        i_valid <= 1'b0;

        while (pending_out_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (err_cnt == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

/* filelist.f */
rtl/bpe_pkg.sv
rtl/byte_pair_expander.sv
rtl/bpe_checker.sv
dv/tb_byte_pair_expander.sv
